>>> design/rlm_pkg.sv
`default_nettype none

package rlm_pkg;

    // fixed widths of the item fields and the state
    localparam int SAMPLE_W   = 16;
    localparam int LVL_W      = 16;
    localparam int TOT_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int SUM_W      = 42;
    localparam int DIV_W      = 17;   // holds a block count up to 65536
    localparam int ROOT_W     = SUM_W / 2;
    localparam int DSQ_W      = 26;   // trial subtractor width, covers both uses
    localparam int ACC_W      = 33;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd19661;   // 0.3 in Q0.16
    localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [TOT_W-1:0]  TOT_MAX    = {TOT_W{1'b1}};
    localparam logic [LVL_W-1:0]  LVL_MAX    = {LVL_W{1'b1}};

    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] num;
        logic [DIV_W-1:0] div;
    } t_dsq_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_dsq_stat;

endpackage

`default_nettype wire

>>> design/rms_level_meter_ema.sv
`default_nettype none
// RMS level meter with exponential smoothing.
// Slave stream: one signed sample per item in i_s_tdata, i_s_tlast closes the
// capture block, i_s_tuser[0] starts a new recording (level and total cleared
// before the sample counts). Master stream: one item per closed block, holding
// the smoothed level and the saturating sample total of the recording.
// Config: i_cfg_wen writes the Q0.16 smoothing gain; write only while idle.
// Sequence: a sample that does not close a block passes through idle (accept),
// square and sum before the next accept. A closing sample goes on into the
// shared trial subtractor (42 divide steps, 21 square-root steps, then the
// root is handed over), then the multiply states S_MUL1 and S_MUL2 for the
// average and S_OUT, which loads the output register.
// A block also closes by itself when its count reaches MAX_BLOCK.
// Reset (synchronous, active low) clears sums, counts, level and total, sets
// the gain to 0.3 and drops o_m_tvalid.
// Stall: the output register holds its item until taken; the next samples are
// still accepted, and only a further closing result waits for the register.
module rms_level_meter_ema #(
    parameter int MAX_BLOCK   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config
    input  wire         i_cfg_wen,
    input  wire  [15:0] i_cfg_wdata,   // smoothing_gain
    // sample stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,     // [15:0] sample
    input  wire         i_s_tlast,     // last_in_block
    input  wire  [0:0]  i_s_tuser,     // [0] first_of_recording
    // level stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [47:0] o_m_tdata      // [15:0] level, [47:16] samples_total
);
    import rlm_pkg::*;

    localparam int CW  = $clog2(MAX_BLOCK + 1);
    localparam int SQW = 2 * SAMPLE_BITS;
    localparam int AW  = ((SQW > SUM_W) ? SQW : SUM_W) + 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQR  = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_DSQ  = 7'b0001000,
        S_MUL1 = 7'b0010000,
        S_MUL2 = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [GAIN_W-1:0] r_gain;
    logic [SAMPLE_W-1:0] r_samp;
    logic              r_last;
    logic              r_first;
    logic [SQW-1:0]    r_sq;
    logic [SUM_W-1:0]  r_sum;
    logic [CW-1:0]     r_cnt;
    logic [LVL_W-1:0]  r_level;
    logic [TOT_W-1:0]  r_total;
    logic [LVL_W-1:0]  r_rms;
    logic [ACC_W-1:0]  r_acc;
    logic              r_m_valid;
    logic [47:0]       r_m_data;

    logic [SAMPLE_BITS-1:0] w_v;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [AW-1:0]     w_sum_ext;
    logic [SUM_W-1:0]  n_sum;
    logic [CW-1:0]     n_cnt;
    logic              w_close;
    logic [GAIN_W:0]   w_inv_gain;
    logic              w_out_free;
    t_dsq_req          w_req;
    t_dsq_stat         w_stat;

    rlm_divsqrt u_dsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_stat  (w_stat)
    );

    // magnitude of the low SAMPLE_BITS bits, most negative code included
    assign w_v   = SAMPLE_BITS'(r_samp);
    assign w_mag = w_v[SAMPLE_BITS-1] ? (~w_v + 1'b1) : w_v;

    assign w_sum_ext = AW'(r_sum) + AW'(r_sq);
    assign n_sum     = (w_sum_ext > AW'(SUM_MAX)) ? SUM_MAX : w_sum_ext[SUM_W-1:0];
    assign n_cnt     = r_cnt + 1'b1;
    assign w_close   = r_last || (n_cnt == CW'(MAX_BLOCK));

    assign w_inv_gain = 17'h10000 - {1'b0, r_gain};
    assign w_out_free = !r_m_valid || i_m_tready;

    assign w_req.start = (r_state == S_ACC) && w_close;
    assign w_req.num   = n_sum;
    assign w_req.div   = DIV_W'(n_cnt);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_s_tvalid) n_state = S_SQR;
            S_SQR:  n_state = S_ACC;
            S_ACC:  n_state = w_close ? S_DSQ : S_IDLE;
            S_DSQ:  if (w_stat.done) n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_OUT;
            S_OUT:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_gain    <= GAIN_RESET;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_level   <= '0;
            r_total   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wen) begin
                r_gain <= i_cfg_wdata;
            end
            // a new result refills the register in the cycle the old one leaves
            if (r_state == S_OUT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_SQR: begin
                    if (r_first) begin
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_level <= '0;
                        r_total <= '0;
                    end
                end
                S_ACC: begin
                    if (r_total != TOT_MAX) begin
                        r_total <= r_total + 1'b1;
                    end
                    if (w_close) begin
                        r_sum <= '0;
                        r_cnt <= '0;
                    end else begin
                        r_sum <= n_sum;
                        r_cnt <= n_cnt;
                    end
                end
                S_MUL2: begin
                    r_level <= LVL_W'((r_acc + ACC_W'(r_rms) * ACC_W'(r_gain)) >> 16);
                end
                default: begin
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_samp  <= i_s_tdata;
            r_last  <= i_s_tlast;
            r_first <= i_s_tuser[0];
        end
        if (r_state == S_SQR) begin
            r_sq <= SQW'(w_mag) * SQW'(w_mag);
        end
        if (r_state == S_DSQ && w_stat.done) begin
            r_rms <= (w_stat.root > ROOT_W'(LVL_MAX)) ? LVL_MAX : LVL_W'(w_stat.root);
        end
        if (r_state == S_MUL1) begin
            // old level weighted by 1 - gain, plus half an LSB for rounding
            r_acc <= ACC_W'(r_level) * ACC_W'(w_inv_gain) + ACC_W'(32768);
        end
        if (r_state == S_OUT && w_out_free) begin
            r_m_data <= {r_total, r_level};
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

`default_nettype wire

>>> design/rlm_divsqrt.sv
`default_nettype none

module rlm_divsqrt (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rlm_pkg::t_dsq_req   i_req,
    output rlm_pkg::t_dsq_stat  o_stat
);
    import rlm_pkg::*;

    // one restoring step per cycle: first the quotient, then the root of it
    logic              r_busy;
    logic              r_sqrt;
    logic [5:0]        r_step;
    logic              r_done;
    logic [SUM_W-1:0]  r_num;
    logic [DSQ_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div;
    logic [ROOT_W-1:0] r_root;

    logic [DSQ_W-1:0]  w_a;
    logic [DSQ_W-1:0]  w_b;
    logic [DSQ_W:0]    w_diff;
    logic              w_ge;

    always_comb begin
        if (r_sqrt) begin
            w_a = {r_rem[DSQ_W-3:0], r_num[SUM_W-1 -: 2]};
            w_b = DSQ_W'({r_root, 2'b01});
        end else begin
            w_a = {r_rem[DSQ_W-2:0], r_num[SUM_W-1]};
            w_b = DSQ_W'(r_div);
        end
        w_diff = {1'b0, w_a} - {1'b0, w_b};
        w_ge   = !w_diff[DSQ_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sqrt <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_sqrt <= 1'b0;
                r_step <= '0;
            end else if (r_busy) begin
                if (!r_sqrt && r_step == 6'(DIV_STEPS - 1)) begin
                    r_sqrt <= 1'b1;
                    r_step <= '0;
                end else if (r_sqrt && r_step == 6'(SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= i_req.num;
            r_div  <= i_req.div;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            if (r_sqrt) begin
                r_rem  <= w_ge ? w_diff[DSQ_W-1:0] : w_a;
                r_num  <= {r_num[SUM_W-3:0], 2'b00};
                r_root <= {r_root[ROOT_W-2:0], w_ge};
            end else begin
                // quotient bits shift in behind the numerator
                r_num  <= {r_num[SUM_W-2:0], w_ge};
                if (r_step == 6'(DIV_STEPS - 1)) begin
                    r_rem <= '0;
                end else begin
                    r_rem <= w_ge ? w_diff[DSQ_W-1:0] : w_a;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.root = r_root;

endmodule

`default_nettype wire
